// ===== design/tps_pkg.sv =====
package tps_pkg;

	localparam int COORD_BITS_DEF = 21;
	localparam int FIELD_W        = 63;

	localparam logic SIDE_POS = 1'b0;
	localparam logic SIDE_NEG = 1'b1;

	typedef struct packed {
		logic [FIELD_W-1:0] plane_point_a;
		logic [FIELD_W-1:0] plane_point_b;
		logic [FIELD_W-1:0] plane_point_c;
		logic [FIELD_W-1:0] corner_0;
		logic [FIELD_W-1:0] corner_1;
		logic [FIELD_W-1:0] corner_2;
		logic [7:0]         mesh_index;
		logic [31:0]        primitive_id;
	} in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] frag_corner_0;
		logic [FIELD_W-1:0] frag_corner_1;
		logic [FIELD_W-1:0] frag_corner_2;
		logic               fragment_side;
		logic [7:0]         mesh_out;
		logic [31:0]        primitive_out;
		logic               last_fragment;
	} out_t;

	typedef enum logic [1:0] {
		SPLIT_POS,
		SPLIT_NEG,
		SPLIT_ZERO,
		SPLIT_LONE
	} split_t;

	typedef enum logic [1:0] {
		LM_ZERO,
		LM_ONE,
		LM_FRAC
	} lmode_t;

endpackage

// ===== design/triangle_plane_splitter.sv =====
// triangle_plane_splitter
// Input channel: item carries a cutting plane (three points), a triangle and a tag.
// An item is taken at a rising edge where start is high and busy is low.
// Output channel: each fragment is shown on result for one cycle with strobe high;
// the receiver takes it at the end of that cycle and cannot hold it off.
// One item gives one, two or three fragments, positive side first, and
// last_fragment marks the final one of each item.
// The first fragment of an item shows once the item has passed every pipeline stage
// and entered the fragment buffer; the rest follow one per cycle.
// Throughput: a new item every cycle while the items give one fragment each;
// an item that gives more fragments holds new items off while its fragments leave
// one per cycle. The output fragment buffer sets this limit:
// busy is high while the item at the pipeline end waits for that buffer.
// The pipeline: operand differences, normal products, plane distances from split
// partial products, classification, clamp of t, scaled offsets, then a restoring
// divider with one quotient bit per stage for each of six lerp axes.
// Reset clears the stage valid bits and the fragment buffer; no item is lost
// or repeated when the pipeline holds.
module triangle_plane_splitter #(
	parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  tps_pkg::in_t item,
	output logic         strobe,
	output tps_pkg::out_t result
);
	import tps_pkg::*;

	localparam int CW    = COORD_BITS;
	localparam int EW    = CW + 1;
	localparam int PW    = 2 * EW;
	localparam int NCW   = PW + 1;
	localparam int NL    = EW + 1;
	localparam int NH    = NCW - NL;
	localparam int PHW   = NH + EW;
	localparam int PLW   = NL + 1 + EW;
	localparam int PRW   = NCW + EW;
	localparam int DW    = PRW + 2;
	localparam int QB    = EW;
	localparam int NW    = DW + QB + 2;
	localparam int SW    = (DW + 2) / 3;
	localparam int PPW   = SW + QB;
	localparam int PKW   = 3 * CW;
	localparam int S_NUM = 11;
	localparam int LAST  = S_NUM + QB;

	typedef struct packed {
		split_t                         kind;
		logic                           first_pos;
		logic [1:0]                     p0;
		logic [1:0]                     p1;
		logic [1:0]                     p2;
		logic [1:0][2:0][CW-1:0]        la;
		lmode_t [1:0]                   mode;
		logic [1:0][2:0][EW-1:0]        dlt;
	} geo_t;

	function automatic logic signed [CW-1:0] coord(logic [FIELD_W-1:0] v, int k);
		return signed'(v[CW*(2-k) +: CW]);
	endfunction

	function automatic logic [FIELD_W-1:0] corner_of(in_t it, logic [1:0] i);
		logic [FIELD_W-1:0] r;
		unique case (i)
			2'd0: r = it.corner_0;
			2'd1: r = it.corner_1;
			default: r = it.corner_2;
		endcase
		return r;
	endfunction

	function automatic out_t mk(logic [FIELD_W-1:0] v0, logic [FIELD_W-1:0] v1,
			logic [FIELD_W-1:0] v2, logic side, logic [7:0] mi, logic [31:0] pid);
		out_t o;
		o.frag_corner_0 = v0;
		o.frag_corner_1 = v1;
		o.frag_corner_2 = v2;
		o.fragment_side = side;
		o.mesh_out      = mi;
		o.primitive_out = pid;
		o.last_fragment = 1'b0;
		return o;
	endfunction

	logic adv;

	logic valid_s [1:LAST];
	in_t  item_s  [1:LAST];

	logic signed [CW-1:0]  pa [3];
	logic signed [CW-1:0]  pb [3];
	logic signed [CW-1:0]  pc [3];
	logic signed [CW-1:0]  tp1 [3][3];
	logic signed [CW-1:0]  tp7 [3][3];

	logic signed [EW-1:0]  u_s2 [3];
	logic signed [EW-1:0]  v_s2 [3];
	logic signed [EW-1:0]  e_s2 [3][3];
	logic signed [EW-1:0]  e_s3 [3][3];
	logic signed [EW-1:0]  e_s4 [3][3];
	logic signed [PW-1:0]  pr_s3 [6];
	logic signed [NCW-1:0] n_s4 [3];
	logic signed [PHW-1:0] ph_s5 [3][3];
	logic signed [PLW-1:0] pl_s5 [3][3];
	logic signed [PRW-1:0] m_s6 [3][3];
	logic signed [DW-1:0]  d_s7 [3];

	geo_t                  geo_s [8:LAST];
	logic signed [CW-1:0]  lb_s8 [2][3];
	logic signed [DW-1:0]  da_s8 [2];
	logic signed [DW:0]    den_s8 [2];

	logic [DW-1:0]         n0_s9 [2];
	logic [DW:0]           dd_s9 [2];
	logic [QB-1:0]         mag_s9 [2][3];

	logic [PPW-1:0]        pp_s10 [2][3][3];
	logic [DW:0]           dd_s10 [2];

	logic [NW-1:0]         rem_s [S_NUM:LAST-1][2][3];
	logic [QB-1:0]         quo_s [S_NUM:LAST][2][3];
	logic [DW+1:0]         dv_s  [S_NUM:LAST-1][2];

	// classification
	logic [2:0]            pos8, neg8, zer8, lmask8;
	logic [1:0]            npos8, nzer8, lone8, zi8;
	logic [1:0]            ia8 [2];
	logic [1:0]            ib8 [2];
	geo_t                  geo8;
	logic signed [CW-1:0]  lb8 [2][3];
	logic signed [DW-1:0]  da8 [2];
	logic signed [DW-1:0]  db8 [2];

	// clamp of t
	geo_t                  geo9;
	logic [DW-1:0]         n0_9 [2];
	logic [DW:0]           dd_9 [2];
	logic signed [EW-1:0]  dlt_9 [2][3];
	logic [QB-1:0]         mag_9 [2][3];
	logic [3*SW-1:0]       n0p [2];

	// fragment build
	logic signed [EW:0]    off_f [2][3];
	logic signed [EW:0]    sum_f [2][3];
	logic [CW-1:0]         np_f [2][3];
	logic [FIELD_W-1:0]    npk [2];
	logic [FIELD_W-1:0]    tcf [3];
	logic [FIELD_W-1:0]    tcp [3];
	out_t                  fb [3];
	logic [1:0]            fn;

	logic [1:0]            cnt_q;
	logic [1:0]            idx_q;
	out_t                  frag_q [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pa[k] = coord(item_s[1].plane_point_a, k);
			pb[k] = coord(item_s[1].plane_point_b, k);
			pc[k] = coord(item_s[1].plane_point_c, k);
			tp1[0][k] = coord(item_s[1].corner_0, k);
			tp1[1][k] = coord(item_s[1].corner_1, k);
			tp1[2][k] = coord(item_s[1].corner_2, k);
			tp7[0][k] = coord(item_s[7].corner_0, k);
			tp7[1][k] = coord(item_s[7].corner_1, k);
			tp7[2][k] = coord(item_s[7].corner_2, k);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pos8[i] = d_s7[i][DW-1];
			zer8[i] = (d_s7[i] == '0);
			neg8[i] = !pos8[i] && !zer8[i];
		end
		npos8  = 2'(pos8[0]) + 2'(pos8[1]) + 2'(pos8[2]);
		nzer8  = 2'(zer8[0]) + 2'(zer8[1]) + 2'(zer8[2]);
		lmask8 = (npos8 == 2'd1) ? pos8 : neg8;
		lone8  = lmask8[0] ? 2'd0 : (lmask8[1] ? 2'd1 : 2'd2);
		zi8    = zer8[0] ? 2'd0 : (zer8[1] ? 2'd1 : 2'd2);
		geo8   = '0;
		geo8.p0 = 2'd0;
		geo8.p1 = 2'd1;
		geo8.p2 = 2'd2;
		ia8[0] = 2'd0;
		ia8[1] = 2'd0;
		ib8[0] = 2'd1;
		ib8[1] = 2'd2;
		priority if (neg8 == '0) begin
			geo8.kind = SPLIT_POS;
		end else if (pos8 == '0) begin
			geo8.kind = SPLIT_NEG;
		end else if (nzer8 == 2'd1) begin
			geo8.kind = SPLIT_ZERO;
			geo8.p0   = zi8;
			geo8.p1   = (zi8 == 2'd2) ? 2'd0 : zi8 + 2'd1;
			geo8.p2   = (zi8 == 2'd0) ? 2'd2 : zi8 - 2'd1;
			geo8.first_pos = pos8[geo8.p1];
			ia8[0] = geo8.p1;
			ia8[1] = geo8.p1;
			ib8[0] = geo8.p2;
			ib8[1] = geo8.p2;
		end else begin
			geo8.kind = SPLIT_LONE;
			geo8.p0   = lone8;
			geo8.p1   = (lone8 == 2'd0) ? 2'd1 : 2'd0;
			geo8.p2   = (lone8 == 2'd2) ? 2'd1 : 2'd2;
			geo8.first_pos = (npos8 == 2'd1);
			ia8[0] = lone8;
			ia8[1] = lone8;
			ib8[0] = geo8.p1;
			ib8[1] = geo8.p2;
		end
		for (int j = 0; j < 2; j++) begin
			for (int x = 0; x < 3; x++) begin
				geo8.la[j][x] = tp7[ia8[j]][x];
				lb8[j][x]     = tp7[ib8[j]][x];
			end
			da8[j] = d_s7[ia8[j]];
			db8[j] = d_s7[ib8[j]];
		end
	end

	always_comb begin
		geo9 = geo_s[8];
		for (int j = 0; j < 2; j++) begin
			if (den_s8[j] == '0) begin
				n0_9[j] = DW'(1);
				dd_9[j] = (DW+1)'(2);
				geo9.mode[j] = LM_FRAC;
			end else begin
				n0_9[j] = da_s8[j][DW-1] ? DW'(-da_s8[j]) : DW'(da_s8[j]);
				dd_9[j] = den_s8[j][DW] ? (DW+1)'(-den_s8[j]) : (DW+1)'(den_s8[j]);
				priority if (da_s8[j] == '0 || da_s8[j][DW-1] != den_s8[j][DW]) begin
					geo9.mode[j] = LM_ZERO;
				end else if ((DW+1)'(n0_9[j]) >= dd_9[j]) begin
					geo9.mode[j] = LM_ONE;
				end else begin
					geo9.mode[j] = LM_FRAC;
				end
			end
			for (int x = 0; x < 3; x++) begin
				dlt_9[j][x] = EW'(lb_s8[j][x]) - EW'(signed'(geo_s[8].la[j][x]));
				mag_9[j][x] = dlt_9[j][x][EW-1] ? QB'(-dlt_9[j][x]) : QB'(dlt_9[j][x]);
				geo9.dlt[j][x] = dlt_9[j][x];
			end
			n0p[j] = (3*SW)'(n0_s9[j]);
		end
	end

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			for (int x = 0; x < 3; x++) begin
				unique case (geo_s[LAST].mode[j])
					LM_ZERO: off_f[j][x] = '0;
					LM_ONE:  off_f[j][x] = (EW+1)'(signed'(geo_s[LAST].dlt[j][x]));
					LM_FRAC: off_f[j][x] = geo_s[LAST].dlt[j][x][EW-1]
						? -signed'({1'b0, quo_s[LAST][j][x]})
						: signed'({1'b0, quo_s[LAST][j][x]});
					default: off_f[j][x] = '0;
				endcase
				sum_f[j][x] = (EW+1)'(signed'(geo_s[LAST].la[j][x])) + off_f[j][x];
				np_f[j][x]  = sum_f[j][x][CW-1:0];
			end
			npk[j] = FIELD_W'({np_f[j][0], np_f[j][1], np_f[j][2]});
		end
		for (int i = 0; i < 3; i++) begin
			tcf[i] = corner_of(item_s[LAST], 2'(i));
			tcp[i] = FIELD_W'(tcf[i][PKW-1:0]);
		end
		for (int i = 0; i < 3; i++) begin
			fb[i] = '0;
		end
		unique case (geo_s[LAST].kind)
			SPLIT_POS: begin
				fb[0] = mk(tcp[0], tcp[1], tcp[2], SIDE_POS,
					item_s[LAST].mesh_index, item_s[LAST].primitive_id);
				fn = 2'd1;
			end
			SPLIT_NEG: begin
				fb[0] = mk(tcp[0], tcp[1], tcp[2], SIDE_NEG,
					item_s[LAST].mesh_index, item_s[LAST].primitive_id);
				fn = 2'd1;
			end
			SPLIT_ZERO: begin
				if (geo_s[LAST].first_pos) begin
					fb[0] = mk(tcp[geo_s[LAST].p0], tcp[geo_s[LAST].p1], npk[0], SIDE_POS,
						item_s[LAST].mesh_index, item_s[LAST].primitive_id);
					fb[1] = mk(tcp[geo_s[LAST].p0], npk[0], tcp[geo_s[LAST].p2], SIDE_NEG,
						item_s[LAST].mesh_index, item_s[LAST].primitive_id);
				end else begin
					fb[0] = mk(tcp[geo_s[LAST].p0], npk[0], tcp[geo_s[LAST].p2], SIDE_POS,
						item_s[LAST].mesh_index, item_s[LAST].primitive_id);
					fb[1] = mk(tcp[geo_s[LAST].p0], tcp[geo_s[LAST].p1], npk[0], SIDE_NEG,
						item_s[LAST].mesh_index, item_s[LAST].primitive_id);
				end
				fn = 2'd2;
			end
			SPLIT_LONE: begin
				if (geo_s[LAST].first_pos) begin
					fb[0] = mk(tcp[geo_s[LAST].p0], npk[0], npk[1], SIDE_POS,
						item_s[LAST].mesh_index, item_s[LAST].primitive_id);
					fb[1] = mk(npk[0], tcp[geo_s[LAST].p1], tcp[geo_s[LAST].p2], SIDE_NEG,
						item_s[LAST].mesh_index, item_s[LAST].primitive_id);
					fb[2] = mk(npk[0], tcp[geo_s[LAST].p2], npk[1], SIDE_NEG,
						item_s[LAST].mesh_index, item_s[LAST].primitive_id);
				end else begin
					fb[0] = mk(npk[0], tcp[geo_s[LAST].p1], tcp[geo_s[LAST].p2], SIDE_POS,
						item_s[LAST].mesh_index, item_s[LAST].primitive_id);
					fb[1] = mk(npk[0], tcp[geo_s[LAST].p2], npk[1], SIDE_POS,
						item_s[LAST].mesh_index, item_s[LAST].primitive_id);
					fb[2] = mk(tcp[geo_s[LAST].p0], npk[0], npk[1], SIDE_NEG,
						item_s[LAST].mesh_index, item_s[LAST].primitive_id);
				end
				fn = 2'd3;
			end
		endcase
		fb[fn - 2'd1].last_fragment = 1'b1;
	end

	assign adv    = !valid_s[LAST] || (cnt_q <= 2'd1);
	assign busy   = !adv;
	assign strobe = (cnt_q != 2'd0);
	assign result = frag_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (adv) begin
			valid_s[1] <= start;
			for (int k = 2; k <= LAST; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s[1] <= item;
			for (int k = 2; k <= LAST; k++) begin
				item_s[k] <= item_s[k-1];
			end
			// edge vectors
			for (int k = 0; k < 3; k++) begin
				u_s2[k] <= EW'(pb[k]) - EW'(pa[k]);
				v_s2[k] <= EW'(pc[k]) - EW'(pa[k]);
				for (int c = 0; c < 3; c++) begin
					e_s2[c][k] <= EW'(tp1[c][k]) - EW'(pa[k]);
				end
			end
			// normal
			pr_s3[0] <= PW'(u_s2[1]) * PW'(v_s2[2]);
			pr_s3[1] <= PW'(u_s2[2]) * PW'(v_s2[1]);
			pr_s3[2] <= PW'(u_s2[2]) * PW'(v_s2[0]);
			pr_s3[3] <= PW'(u_s2[0]) * PW'(v_s2[2]);
			pr_s3[4] <= PW'(u_s2[0]) * PW'(v_s2[1]);
			pr_s3[5] <= PW'(u_s2[1]) * PW'(v_s2[0]);
			e_s3 <= e_s2;
			n_s4[0] <= NCW'(pr_s3[0]) - NCW'(pr_s3[1]);
			n_s4[1] <= NCW'(pr_s3[2]) - NCW'(pr_s3[3]);
			n_s4[2] <= NCW'(pr_s3[4]) - NCW'(pr_s3[5]);
			e_s4 <= e_s3;
			// plane distances
			for (int c = 0; c < 3; c++) begin
				for (int x = 0; x < 3; x++) begin
					ph_s5[c][x] <= PHW'(signed'(n_s4[x][NCW-1:NL])) * PHW'(e_s4[c][x]);
					pl_s5[c][x] <= PLW'(signed'({1'b0, n_s4[x][NL-1:0]})) * PLW'(e_s4[c][x]);
					m_s6[c][x]  <= (PRW'(ph_s5[c][x]) <<< NL) + PRW'(pl_s5[c][x]);
				end
				d_s7[c] <= DW'(m_s6[c][0]) + DW'(m_s6[c][1]) + DW'(m_s6[c][2]);
			end
			geo_s[8] <= geo8;
			for (int j = 0; j < 2; j++) begin
				lb_s8[j]  <= lb8[j];
				da_s8[j]  <= da8[j];
				den_s8[j] <= (DW+1)'(da8[j]) - (DW+1)'(db8[j]);
			end
			geo_s[9] <= geo9;
			for (int k = 10; k <= LAST; k++) begin
				geo_s[k] <= geo_s[k-1];
			end
			for (int j = 0; j < 2; j++) begin
				n0_s9[j]  <= n0_9[j];
				dd_s9[j]  <= dd_9[j];
				mag_s9[j] <= mag_9[j];
				dd_s10[j] <= dd_s9[j];
				dv_s[S_NUM][j] <= {dd_s10[j], 1'b0};
				for (int k = S_NUM + 1; k <= LAST - 1; k++) begin
					dv_s[k][j] <= dv_s[k-1][j];
				end
				for (int x = 0; x < 3; x++) begin
					for (int s = 0; s < 3; s++) begin
						pp_s10[j][x][s] <= PPW'(n0p[j][s*SW +: SW]) * PPW'(mag_s9[j][x]);
					end
					rem_s[S_NUM][j][x] <= (((NW'(pp_s10[j][x][2]) << (2*SW))
						+ (NW'(pp_s10[j][x][1]) << SW)
						+ NW'(pp_s10[j][x][0])) << 1) + NW'(dd_s10[j]);
					quo_s[S_NUM][j][x] <= '0;
					// restoring divider, one quotient bit per stage
					for (int k = S_NUM + 1; k <= LAST; k++) begin
						if (rem_s[k-1][j][x] >= (NW'(dv_s[k-1][j]) << (LAST - k))) begin
							if (k < LAST) begin
								rem_s[k][j][x] <= rem_s[k-1][j][x]
									- (NW'(dv_s[k-1][j]) << (LAST - k));
							end
							quo_s[k][j][x] <= quo_s[k-1][j][x] | (QB'(1) << (LAST - k));
						end else begin
							if (k < LAST) begin
								rem_s[k][j][x] <= rem_s[k-1][j][x];
							end
							quo_s[k][j][x] <= quo_s[k-1][j][x];
						end
					end
				end
			end
		end
	end

	// fragment buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (adv && valid_s[LAST]) begin
			cnt_q <= fn;
			idx_q <= 2'd0;
		end else if (cnt_q != 2'd0) begin
			cnt_q <= cnt_q - 2'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s[LAST]) begin
			frag_q <= fb;
		end
	end

endmodule

// ===== design/tps_checker.sv =====
module tps_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          strobe,
	input tps_pkg::out_t result
);
	import tps_pkg::*;

	// fragments of one item come back to back
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_fragment |=> strobe)
		else $error("fragment run broken");

	// the block only holds items off while a fragment run is under way
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> strobe && !result.last_fragment)
		else $error("busy without pending fragments");

	// positive fragments come before negative ones
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.fragment_side && !result.last_fragment |=> result.fragment_side)
		else $error("positive fragment after negative");

	// tag stays the same within one item
	a_tag: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_fragment |=>
			$stable(result.mesh_out) && $stable(result.primitive_out))
		else $error("tag changed within item");

	// a held-off item means more fragments follow
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> strobe)
		else $error("busy without a following fragment");

endmodule

bind triangle_plane_splitter tps_checker u_tps_checker (.*);
